// ===== rtl/bdlm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdlm_pkg
// Shared types and constants for the button debounced LED mode controller.
// ----------------------------------------------------------------------------
package bdlm_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_AT      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_PRESCALE = 2'd2;

    // Register reset values
    localparam logic [7:0] HOLD_TICKS_RST     = 8'd80;
    localparam logic [7:0] SAMPLE_AT_RST      = 8'd76;
    localparam logic [7:0] BLINK_PRESCALE_RST = 8'd30;

    // Input word action codes
    localparam logic ACT_DEBOUNCE = 1'b0;
    localparam logic ACT_BLINK    = 1'b1;

    // Button combinations that do something
    localparam logic [2:0] BTN_1   = 3'b001;
    localparam logic [2:0] BTN_2   = 3'b010;
    localparam logic [2:0] BTN_3   = 3'b100;
    localparam logic [2:0] BTN_1_2 = 3'b011;
    localparam logic [2:0] BTN_1_3 = 3'b101;

    // LED patterns
    localparam logic [2:0] LED_NONE = 3'b000;
    localparam logic [2:0] LED_1    = 3'b001;
    localparam logic [2:0] LED_2    = 3'b010;
    localparam logic [2:0] LED_3    = 3'b100;
    localparam logic [2:0] LED_ALL  = 3'b111;

    typedef enum logic [1:0] {
        MODE_MANUAL    = 2'd0,
        MODE_ALL_BLINK = 2'd1,
        MODE_CHASE     = 2'd2
    } t_mode;

    typedef struct packed {
        logic [7:0] hold_ticks;
        logic [7:0] sample_at;
        logic [7:0] blink_prescale;
    } t_cfg;

    typedef struct packed {
        logic       action;
        logic [2:0] buttons_pressed;
    } t_item;

endpackage

// ===== rtl/bdlm_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdlm_in_if
// Input channel: tick type and button levels.
// ----------------------------------------------------------------------------
interface bdlm_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [2:0] buttons_pressed;

    modport source (output valid, output action, output buttons_pressed, input ready);
    modport sink   (input valid, input action, input buttons_pressed, output ready);
endinterface

// ===== rtl/bdlm_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdlm_out_if
// Output channel: LED drive levels.
// ----------------------------------------------------------------------------
interface bdlm_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] led_out;

    modport source (output valid, output led_out, input ready);
    modport sink   (input valid, input led_out, output ready);
endinterface

// ===== rtl/bdlm_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdlm_cfg_regs
// Configuration register file: window length, sample point, blink prescale.
// ----------------------------------------------------------------------------
module bdlm_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bdlm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [7:0]                      i_cfg_data,
    output bdlm_pkg::t_cfg                  o_cfg
);
    import bdlm_pkg::*;

    t_cfg r_cfg;

    // Register writes; out-of-range indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hold_ticks     <= HOLD_TICKS_RST;
            r_cfg.sample_at      <= SAMPLE_AT_RST;
            r_cfg.blink_prescale <= BLINK_PRESCALE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HOLD_TICKS:     r_cfg.hold_ticks     <= i_cfg_data;
                CFG_SAMPLE_AT:      r_cfg.sample_at      <= i_cfg_data;
                CFG_BLINK_PRESCALE: r_cfg.blink_prescale <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/bdlm_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdlm_core
// Controller state and its one-word update: press window, button decode,
// mode changes and blink pattern stepping.
// ----------------------------------------------------------------------------
module bdlm_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bdlm_pkg::t_cfg i_cfg,
    input  logic           i_adv,
    input  bdlm_pkg::t_item i_item,
    output logic [2:0]     o_led_next
);
    import bdlm_pkg::*;

    logic [2:0] r_leds,  n_leds;
    t_mode      r_mode,  n_mode;
    logic [7:0] r_cnt,   n_cnt;
    logic       r_open,  n_open;
    logic       r_sok,   n_sok;
    logic       r_acted, n_acted;
    logic [7:0] r_bcnt,  n_bcnt;

    logic [7:0] w_cnt_dec;

    // Next state for one word
    always_comb begin
        n_leds    = r_leds;
        n_mode    = r_mode;
        n_cnt     = r_cnt;
        n_open    = r_open;
        n_sok     = r_sok;
        n_acted   = r_acted;
        n_bcnt    = r_bcnt;
        w_cnt_dec = 8'd0;

        if (i_item.action == ACT_DEBOUNCE) begin
            // window opens on any press
            if (!r_open && (i_item.buttons_pressed != 3'd0)) begin
                n_open  = 1'b1;
                n_sok   = 1'b0;
                n_acted = 1'b0;
                n_cnt   = i_cfg.hold_ticks;
            end
            // count down, close at zero
            w_cnt_dec = n_cnt - 8'd1;
            if (n_open) begin
                if (n_cnt != 8'd0) begin
                    if (w_cnt_dec == i_cfg.sample_at) begin
                        n_sok = 1'b1;
                    end
                    n_cnt = w_cnt_dec;
                end else begin
                    n_open = 1'b0;
                end
            end
            // act once per window at the sample point
            if (!n_acted && n_open && n_sok) begin
                n_acted = 1'b1;
                case (i_item.buttons_pressed)
                    BTN_1, BTN_2, BTN_3: begin
                        if (r_mode != MODE_MANUAL) begin
                            n_mode = MODE_MANUAL;
                            n_leds = i_item.buttons_pressed;
                        end else begin
                            n_leds = r_leds ^ i_item.buttons_pressed;
                        end
                    end
                    BTN_1_2: begin
                        if (r_mode != MODE_ALL_BLINK) begin
                            n_mode = MODE_ALL_BLINK;
                            n_leds = LED_NONE;
                        end
                    end
                    BTN_1_3: begin
                        if (r_mode != MODE_CHASE) begin
                            n_mode = MODE_CHASE;
                            n_leds = LED_NONE;
                        end
                    end
                    default: ;
                endcase
            end
        end else if (r_mode != MODE_MANUAL) begin
            // blink prescaler and pattern step
            if (r_bcnt == i_cfg.blink_prescale) begin
                n_bcnt = 8'd0;
                case (r_mode)
                    MODE_ALL_BLINK: n_leds = r_leds ^ LED_ALL;
                    MODE_CHASE: begin
                        if (r_leds == LED_1) begin
                            n_leds = LED_2;
                        end else if (r_leds == LED_2) begin
                            n_leds = LED_3;
                        end else begin
                            n_leds = LED_1;
                        end
                    end
                    default: ;
                endcase
            end else begin
                n_bcnt = r_bcnt + 8'd1;
            end
        end
    end

    // State registers, updated when a word moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leds  <= LED_NONE;
            r_mode  <= MODE_MANUAL;
            r_cnt   <= 8'd0;
            r_open  <= 1'b0;
            r_sok   <= 1'b0;
            r_acted <= 1'b0;
            r_bcnt  <= 8'd0;
        end else if (i_adv) begin
            r_leds  <= n_leds;
            r_mode  <= n_mode;
            r_cnt   <= n_cnt;
            r_open  <= n_open;
            r_sok   <= n_sok;
            r_acted <= n_acted;
            r_bcnt  <= n_bcnt;
        end
    end

    assign o_led_next = n_leds;

    // Checks
    a_act_needs_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_acted) |-> (r_open && r_sok))
        else $error("acted set outside an open, sampled window");

    a_chase_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_CHASE) |-> $onehot0(r_leds))
        else $error("chase mode with more than one LED lit");

    a_prescale_manual_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_mode) == MODE_MANUAL) |-> $stable(r_bcnt))
        else $error("blink prescaler moved in manual mode");

    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_adv) |-> ($stable(r_leds) && $stable(r_cnt)))
        else $error("state changed without a word");

endmodule

// ===== rtl/button_debounced_led_mode_controller_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounced_led_mode_controller_top
// Three-button, three-LED controller: debounce window, manual toggles,
// all-blink and chase modes.
// ----------------------------------------------------------------------------
// Path: an accepted word is held in the input register, then the state update
//   writes its result into the result register, where it is presented as valid.
// Throughput: one word per cycle unless the output stalls; the state update is a single short pass.
// Reset: synchronous, active low; clears pipeline valids and all controller state and
//   loads the register defaults (80, 76, 30).
module button_debounced_led_mode_controller_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bdlm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]                     i_cfg_data,
    bdlm_in_if.sink                        i_item,
    bdlm_out_if.source                     o_res
);
    import bdlm_pkg::*;

    t_cfg       w_cfg;
    t_item      r_in;
    logic       r_in_valid;
    logic [2:0] r_led;
    logic       r_out_valid;
    logic       w_adv;
    logic       w_take;
    logic [2:0] w_led_next;

    // Pipeline handshake
    assign w_adv        = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_item.ready = !r_in_valid || w_adv;
    assign w_take       = i_item.valid && i_item.ready;

    bdlm_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    bdlm_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_adv      (w_adv),
        .i_item     (r_in),
        .o_led_next (w_led_next)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_take) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in.action          <= i_item.action;
            r_in.buttons_pressed <= i_item.buttons_pressed;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_led <= w_led_next;
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.led_out = r_led;

endmodule
